// ===== rtl/rbei_pkg.sv =====
// -----------------------------------------------------------------------------
// rbei_pkg: shared codes for the rigid body Euler integrator
// Body kinds, outcome codes and configuration register indexes.
// -----------------------------------------------------------------------------
package rbei_pkg;

  localparam logic [1:0] KIND_INERT     = 2'd0;
  localparam logic [1:0] KIND_KINEMATIC = 2'd1;
  localparam logic [1:0] KIND_DYNAMIC   = 2'd2;
  localparam logic [1:0] KIND_UNUSED    = 2'd3;  // handled as inert

  localparam logic [1:0] OUT_MOVED    = 2'd0;
  localparam logic [1:0] OUT_INERT    = 2'd1;
  localparam logic [1:0] OUT_BAD_MASS = 2'd2;
  localparam logic [1:0] OUT_ZERO_DT  = 2'd3;

  localparam logic [1:0] CFG_GRAVITY_X = 2'd0;
  localparam logic [1:0] CFG_GRAVITY_Y = 2'd1;
  localparam logic [1:0] CFG_TIME_STEP = 2'd2;

  localparam int CFG_DATA_W = 32;
  localparam int TS_W       = 31;

endpackage

// ===== rtl/rigid_body_euler_integrator_top.sv =====
// -----------------------------------------------------------------------------
// rigid_body_euler_integrator_top: semi-implicit Euler step for 2D bodies
// One body in, updated velocity, position and outcome out, fully pipelined.
// -----------------------------------------------------------------------------
// Pipeline: the one-bit-per-stage force/mass divider plus the
//   multiply/add stages.
// Throughput: one body per cycle; the whole pipe holds only while the
//   output register is full and not taken.
// Reset: async active low clears all valid bits and the config registers.
module rigid_body_euler_integrator_top #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [rbei_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // body input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // low to high: mass, grav_scale, force_x, force_y, vel_in_x, vel_in_y,
  // damping, speed_limit_x, speed_limit_y, pos_in_x, pos_in_y
  input  logic [((11*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // body_kind
  input  logic [1:0]            s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // low to high: vel_out_x, vel_out_y, pos_out_x, pos_out_y
  output logic [((4*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // outcome
  output logic [1:0]            m_axis_tuser
);

  localparam int W = VALUE_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int OUT_DW = ((4*W+7)/8)*8;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE  = (F >= W-1) ? MAXV : ({{(W-1){1'b0}}, 1'b1} << F);

  typedef struct packed {
    logic [W-1:0] gxm;
    logic [W-1:0] k;
    logic [W-1:0] vx;
    logic [W-1:0] vy;
    logic [W-1:0] lx;
    logic [W-1:0] ly;
    logic [W-1:0] px;
    logic [W-1:0] py;
    logic [1:0]   outc;
    logic         dyn;
  } side_t;

  function automatic logic [W-1:0] sat_add(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) sat_add = s[W] ? MINV : MAXV;
    else sat_add = s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) sat_sub = s[W] ? MINV : MAXV;
    else sat_sub = s[W-1:0];
  endfunction

  // clamp to [-l, +l] when l is positive
  function automatic logic [W-1:0] clamp(logic [W-1:0] v, logic [W-1:0] l);
    logic [W-1:0] nl;
    nl = ~l + 1'b1;
    clamp = v;
    if (!l[W-1] && (l != '0)) begin
      if ($signed(v) > $signed(l)) clamp = l;
      if ($signed(v) < $signed(nl)) clamp = nl;
    end
  endfunction

  // ---------------- configuration ----------------
  logic [W-1:0]              grav_x_q, grav_y_q;
  logic [rbei_pkg::TS_W-1:0] dt_q;
  logic [W-1:0]              dt_w;

  assign cfg_ready_o = 1'b1;
  assign dt_w        = W'(dt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_x_q <= '0;
      grav_y_q <= '0;
      dt_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rbei_pkg::CFG_GRAVITY_X: grav_x_q <= W'($signed(cfg_data_i));
        rbei_pkg::CFG_GRAVITY_Y: grav_y_q <= W'($signed(cfg_data_i));
        rbei_pkg::CFG_TIME_STEP: dt_q     <= cfg_data_i[rbei_pkg::TS_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output register is blocked
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- S0: input capture and classification ----------------
  logic [W-1:0] in_f [0:10];
  for (genvar i = 0; i < 11; i++) begin : g_unpack
    assign in_f[i] = s_axis_tdata[W*i +: W];
  end

  logic [1:0] outc_d;
  always_comb begin
    if (dt_q == '0) begin
      outc_d = rbei_pkg::OUT_ZERO_DT;
    end else if (s_axis_tuser != rbei_pkg::KIND_KINEMATIC &&
                 s_axis_tuser != rbei_pkg::KIND_DYNAMIC) begin
      outc_d = rbei_pkg::OUT_INERT;
    end else if (s_axis_tuser == rbei_pkg::KIND_DYNAMIC &&
                 (in_f[0][W-1] || in_f[0] == '0)) begin
      outc_d = rbei_pkg::OUT_BAD_MASS;
    end else begin
      outc_d = rbei_pkg::OUT_MOVED;
    end
  end

  logic         v0_q, dyn0_q;
  logic [1:0]   outc0_q;
  logic [W-1:0] f0_q [0:10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_q    <= in_f;
      outc0_q <= outc_d;
      dyn0_q  <= (outc_d == rbei_pkg::OUT_MOVED) &&
                 (s_axis_tuser == rbei_pkg::KIND_DYNAMIC);
    end
  end

  // ---------------- S1: gravity and damping products ----------------
  logic [W-1:0] damp_pos, gxm1, gym1, dmp1;
  assign damp_pos = f0_q[6][W-1] ? '0 : f0_q[6];

  rbei_mul #(.W(W), .F(F)) u_mul_gx (
    .clk_i(clk_i), .en_i(en), .a_i(grav_x_q), .b_i(f0_q[1]), .y_o(gxm1));
  rbei_mul #(.W(W), .F(F)) u_mul_gy (
    .clk_i(clk_i), .en_i(en), .a_i(grav_y_q), .b_i(f0_q[1]), .y_o(gym1));
  rbei_mul #(.W(W), .F(F)) u_mul_dmp (
    .clk_i(clk_i), .en_i(en), .a_i(damp_pos), .b_i(dt_w), .y_o(dmp1));

  logic         v1_q, dyn1_q;
  logic [1:0]   outc1_q;
  logic [W-1:0] f1_q [0:10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q    <= f0_q;
      outc1_q <= outc0_q;
      dyn1_q  <= dyn0_q;
    end
  end

  // damping factor, floored at zero
  logic [W-1:0] kk, k1;
  assign kk = sat_sub(ONE, dmp1);
  assign k1 = kk[W-1] ? '0 : kk;

  side_t side_in, side_dx;
  always_comb begin
    side_in.gxm  = gxm1;
    side_in.k    = k1;
    side_in.vx   = f1_q[4];
    side_in.vy   = f1_q[5];
    side_in.lx   = f1_q[7];
    side_in.ly   = f1_q[8];
    side_in.px   = f1_q[9];
    side_in.py   = f1_q[10];
    side_in.outc = outc1_q;
    side_in.dyn  = dyn1_q;
  end

  // ---------------- force / mass dividers ----------------
  logic         vdx, vdy;
  logic [W-1:0] qx, qy, gym_d;

  rbei_div #(.W(W), .F(F), .SW($bits(side_t))) u_div_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(v1_q),
    .num_i(f1_q[2]), .den_i(f1_q[0]), .side_i(side_in),
    .valid_o(vdx), .quot_o(qx), .side_o(side_dx));

  rbei_div #(.W(W), .F(F), .SW(W)) u_div_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(v1_q),
    .num_i(f1_q[3]), .den_i(f1_q[0]), .side_i(gym1),
    .valid_o(vdy), .quot_o(qy), .side_o(gym_d));

  // ---------------- S2: acceleration ----------------
  logic         v2_q;
  side_t        s2_q;
  logic [W-1:0] ax2_q, ay2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= vdx && vdy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q  <= side_dx;
      ax2_q <= sat_add(side_dx.gxm, qx);
      ay2_q <= sat_add(gym_d, qy);
    end
  end

  // ---------------- S3: acceleration * dt ----------------
  logic         v3_q;
  side_t        s3_q;
  logic [W-1:0] dvx3, dvy3;

  rbei_mul #(.W(W), .F(F)) u_mul_ax (
    .clk_i(clk_i), .en_i(en), .a_i(ax2_q), .b_i(dt_w), .y_o(dvx3));
  rbei_mul #(.W(W), .F(F)) u_mul_ay (
    .clk_i(clk_i), .en_i(en), .a_i(ay2_q), .b_i(dt_w), .y_o(dvy3));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) s3_q <= s2_q;
  end

  // ---------------- S4: velocity update ----------------
  logic         v4_q;
  side_t        s4_q;
  logic [W-1:0] wx4_q, wy4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q  <= s3_q;
      wx4_q <= sat_add(s3_q.vx, dvx3);
      wy4_q <= sat_add(s3_q.vy, dvy3);
    end
  end

  // ---------------- S5: damping ----------------
  logic         v5_q;
  side_t        s5_q;
  logic [W-1:0] kx5, ky5;

  rbei_mul #(.W(W), .F(F)) u_mul_kx (
    .clk_i(clk_i), .en_i(en), .a_i(wx4_q), .b_i(s4_q.k), .y_o(kx5));
  rbei_mul #(.W(W), .F(F)) u_mul_ky (
    .clk_i(clk_i), .en_i(en), .a_i(wy4_q), .b_i(s4_q.k), .y_o(ky5));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) s5_q <= s4_q;
  end

  // ---------------- S6: speed clamp (kinematic bodies use input velocity) ----
  logic         v6_q;
  side_t        s6_q;
  logic [W-1:0] cx6_q, cy6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q  <= s5_q;
      cx6_q <= clamp(s5_q.dyn ? kx5 : s5_q.vx, s5_q.lx);
      cy6_q <= clamp(s5_q.dyn ? ky5 : s5_q.vy, s5_q.ly);
    end
  end

  // ---------------- S7: velocity * dt ----------------
  logic         v7_q;
  side_t        s7_q;
  logic [W-1:0] cx7_q, cy7_q, dpx7, dpy7;

  rbei_mul #(.W(W), .F(F)) u_mul_px (
    .clk_i(clk_i), .en_i(en), .a_i(cx6_q), .b_i(dt_w), .y_o(dpx7));
  rbei_mul #(.W(W), .F(F)) u_mul_py (
    .clk_i(clk_i), .en_i(en), .a_i(cy6_q), .b_i(dt_w), .y_o(dpy7));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q  <= s6_q;
      cx7_q <= cx6_q;
      cy7_q <= cy6_q;
    end
  end

  // ---------------- S8: position update, output register ----------------
  logic         moved7;
  logic [W-1:0] ovx_q, ovy_q, opx_q, opy_q;
  logic [1:0]   outc_q;

  assign moved7 = (s7_q.outc == rbei_pkg::OUT_MOVED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= v7_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ovx_q  <= moved7 ? cx7_q : s7_q.vx;
      ovy_q  <= moved7 ? cy7_q : s7_q.vy;
      opx_q  <= moved7 ? sat_add(s7_q.px, dpx7) : s7_q.px;
      opy_q  <= moved7 ? sat_add(s7_q.py, dpy7) : s7_q.py;
      outc_q <= s7_q.outc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DW'({opy_q, opx_q, ovy_q, ovx_q});
  assign m_axis_tuser  = outc_q;

endmodule

// ===== rtl/rbei_mul.sv =====
// -----------------------------------------------------------------------------
// rbei_mul: registered fixed point multiply
// Magnitude product, truncated toward zero by FRAC_BITS, saturated.
// -----------------------------------------------------------------------------
module rbei_mul #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] y_o
);

  localparam logic [W-1:0]   MAXV  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   MINV  = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] PMAX  = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W-1:0] PMINM = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic [W-1:0]   ma, mb;
  logic [2*W-1:0] prod, sh;
  logic           neg;
  logic [W-1:0]   y_d, y_q;

  always_comb begin
    ma   = a_i[W-1] ? (~a_i + 1'b1) : a_i;
    mb   = b_i[W-1] ? (~b_i + 1'b1) : b_i;
    neg  = a_i[W-1] ^ b_i[W-1];
    prod = ma * mb;
    sh   = prod >> F;
    if (!neg) begin
      y_d = (sh > PMAX) ? MAXV : sh[W-1:0];
    end else begin
      y_d = (sh > PMINM) ? MINV : (~sh[W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// ===== rtl/rbei_div.sv =====
// -----------------------------------------------------------------------------
// rbei_div: pipelined restoring divider
// (|num| << F) / |den|, one quotient bit per stage, sign taken from num, saturated.
// -----------------------------------------------------------------------------
module rbei_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quot_o,
  output logic [SW-1:0] side_o
);

  localparam int N = W + F;
  localparam logic [W-1:0] MAXV  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV  = {1'b1, {(W-1){1'b0}}};
  localparam logic [N-1:0] QMAX  = {{(F+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [N-1:0] QMINM = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic          v_q    [0:N];
  logic [W-1:0]  rem_q  [0:N];
  logic [N-1:0]  dvd_q  [0:N];
  logic [N-1:0]  quo_q  [0:N];
  logic [W-1:0]  dm_q   [0:N];
  logic          neg_q  [0:N];
  logic [SW-1:0] side_q [0:N];

  logic [W-1:0] mn_d, md_d;
  assign mn_d = num_i[W-1] ? (~num_i + 1'b1) : num_i;
  assign md_d = den_i[W-1] ? (~den_i + 1'b1) : den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      dvd_q[0]  <= {mn_d, {F{1'b0}}};
      quo_q[0]  <= '0;
      dm_q[0]   <= md_d;
      neg_q[0]  <= num_i[W-1];
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [W:0] t, r;
    logic       ge;
    always_comb begin
      t  = {rem_q[j], dvd_q[j][N-1]};
      ge = (t >= {1'b0, dm_q[j]});
      r  = ge ? (t - {1'b0, dm_q[j]}) : t;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= r[W-1:0];
        dvd_q[j+1]  <= dvd_q[j] << 1;
        quo_q[j+1]  <= {quo_q[j][N-2:0], ge};
        dm_q[j+1]   <= dm_q[j];
        neg_q[j+1]  <= neg_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  logic [W-1:0]  quot_d, quot_q;
  logic [SW-1:0] so_q;
  logic          vo_q;

  always_comb begin
    if (!neg_q[N]) begin
      quot_d = (quo_q[N] > QMAX) ? MAXV : quo_q[N][W-1:0];
    end else begin
      quot_d = (quo_q[N] > QMINM) ? MINV : (~quo_q[N][W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
      so_q   <= side_q[N];
    end
  end

  assign valid_o = vo_q;
  assign quot_o  = quot_q;
  assign side_o  = so_q;

endmodule

// ===== rtl/rbei_checker.sv =====
// -----------------------------------------------------------------------------
// rbei_checker: port-level checks for the integrator
// Output handshake, flow control, reset and config ready rules, bound to the top level.
// -----------------------------------------------------------------------------
module rbei_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_ready_o,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output flow control");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result present right after reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config channel not ready");

endmodule

bind rigid_body_euler_integrator_top rbei_checker u_rbei_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .cfg_ready_o(cfg_ready_o),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

// ===== test/testbench.sv =====
// -----------------------------------------------------------------------------
// testbench: self-checking bench for rigid_body_euler_integrator_top
// Streams 2D bodies through the integrator under several gravity and step
// settings, random stalls on both sides, and checks every result against an
// in-bench fixed point prediction of the Euler step.
// -----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW    = 32;
  localparam int FB    = 16;
  localparam int NF    = 11;          // value fields per body
  localparam int LAT   = VW + FB + 11; // pipeline latency
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;
  localparam longint ONE  = 64'sd1 << FB;

  // field slots in s_axis_tdata, lowest first
  localparam int F_MASS = 0, F_GS = 1, F_FX = 2, F_FY = 3, F_VX = 4, F_VY = 5;
  localparam int F_DAMP = 6, F_LX = 7, F_LY = 8, F_PX = 9, F_PY = 10;

  typedef logic [NF*VW-1:0] body_t;

  typedef struct {
    logic [VW-1:0] vx, vy, px, py;
    logic [1:0]    outcome;
  } motion_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts each body update and holds it until the result shows
  // ---------------------------------------------------------------------------
  class motion_scoreboard;
    longint  gx, gy, dt;
    motion_t pending[$];
    int      errors;
    int      per_outcome[4];

    static function longint sat(longint v);
      return (v > MAXV) ? MAXV : (v < MINV) ? MINV : v;
    endfunction

    // product of two fixed point values, magnitude truncated
    static function longint fmul(longint a, longint b);
      longint unsigned x, y, m;
      x = (a < 0) ? -a : a;
      y = (b < 0) ? -b : b;
      m = (x * y) >> FB;
      return sat(((a < 0) != (b < 0)) ? -longint'(m) : longint'(m));
    endfunction

    // n / d, d > 0
    static function longint fdiv(longint n, longint d);
      longint unsigned x, m;
      x = (n < 0) ? -n : n;
      m = (x << FB) / longint'(d);
      return sat((n < 0) ? -longint'(m) : longint'(m));
    endfunction

    static function longint fld(body_t b, int i);
      return longint'($signed(b[i*VW +: VW]));
    endfunction

    function void note_body(logic [1:0] kind, body_t b);
      motion_t e;
      longint vx, vy, px, py, ax, ay, k, lx, ly, damp;
      vx = fld(b, F_VX); vy = fld(b, F_VY);
      px = fld(b, F_PX); py = fld(b, F_PY);
      lx = fld(b, F_LX); ly = fld(b, F_LY);
      damp = fld(b, F_DAMP);
      if (dt == 0) e.outcome = rbei_pkg::OUT_ZERO_DT;
      else if (kind != rbei_pkg::KIND_KINEMATIC && kind != rbei_pkg::KIND_DYNAMIC)
        e.outcome = rbei_pkg::OUT_INERT;
      else if (kind == rbei_pkg::KIND_DYNAMIC && fld(b, F_MASS) <= 0)
        e.outcome = rbei_pkg::OUT_BAD_MASS;
      else begin
        e.outcome = rbei_pkg::OUT_MOVED;
        if (kind == rbei_pkg::KIND_DYNAMIC) begin
          ax = sat(fmul(gx, fld(b, F_GS)) + fdiv(fld(b, F_FX), fld(b, F_MASS)));
          ay = sat(fmul(gy, fld(b, F_GS)) + fdiv(fld(b, F_FY), fld(b, F_MASS)));
          vx = sat(vx + fmul(ax, dt));
          vy = sat(vy + fmul(ay, dt));
          k = sat(ONE - fmul(damp > 0 ? damp : 0, dt));
          if (k < 0) k = 0;
          vx = fmul(vx, k);
          vy = fmul(vy, k);
        end
        if (lx > 0) begin
          if (vx > lx) vx = lx;
          if (vx < -lx) vx = -lx;
        end
        if (ly > 0) begin
          if (vy > ly) vy = ly;
          if (vy < -ly) vy = -ly;
        end
        px = sat(px + fmul(vx, dt));
        py = sat(py + fmul(vy, dt));
      end
      e.vx = vx[VW-1:0]; e.vy = vy[VW-1:0];
      e.px = px[VW-1:0]; e.py = py[VW-1:0];
      per_outcome[e.outcome]++;
      pending.push_back(e);
    endfunction

    function void check_result(logic [4*VW-1:0] d, logic [1:0] oc);
      motion_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: tdata=%h tuser=%0d", d, oc);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[0*VW +: VW] !== e.vx) begin
        $error("vel_out_x expected %h actual %h", e.vx, d[0*VW +: VW]); errors++;
      end
      if (d[1*VW +: VW] !== e.vy) begin
        $error("vel_out_y expected %h actual %h", e.vy, d[1*VW +: VW]); errors++;
      end
      if (d[2*VW +: VW] !== e.px) begin
        $error("pos_out_x expected %h actual %h", e.px, d[2*VW +: VW]); errors++;
      end
      if (d[3*VW +: VW] !== e.py) begin
        $error("pos_out_y expected %h actual %h", e.py, d[3*VW +: VW]); errors++;
      end
      if (oc !== e.outcome) begin
        $error("outcome expected %0d actual %0d", e.outcome, oc); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = rbei_pkg::CFG_GRAVITY_X;
  logic [rbei_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  body_t s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = rbei_pkg::KIND_INERT;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [4*VW-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  motion_scoreboard sb = new();
  bit no_gaps;       // phase without any idling on either side
  bit stall_done;    // long receiver hold-off has happened
  int results_seen;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  rigid_body_euler_integrator_top #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------
  task automatic send_body(logic [1:0] kind, body_t b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_body(kind, b);
  endtask

  // pause the sender until the pipe has drained completely
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LAT + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [rbei_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      rbei_pkg::CFG_GRAVITY_X: sb.gx = longint'($signed(val));
      rbei_pkg::CFG_GRAVITY_Y: sb.gy = longint'($signed(val));
      rbei_pkg::CFG_TIME_STEP: sb.dt = longint'(val[rbei_pkg::TS_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_world(logic [31:0] gx, logic [31:0] gy, logic [31:0] dt);
    write_reg(rbei_pkg::CFG_GRAVITY_X, gx);
    write_reg(rbei_pkg::CFG_GRAVITY_Y, gy);
    write_reg(rbei_pkg::CFG_TIME_STEP, dt);
  endtask

  // value mix: extremes, tiny, moderate physics-like, and raw random bits
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff;
      4, 5: return $urandom;
      default: return 32'($signed($urandom_range(0, 200 << FB)) - (100 << FB));
    endcase
  endfunction

  function automatic body_t rnd_body(logic [1:0] kind);
    body_t b;
    for (int i = 0; i < NF; i++) b[i*VW +: VW] = rnd_val();
    // mostly sensible masses so dynamic bodies actually integrate
    if (kind == rbei_pkg::KIND_DYNAMIC && $urandom_range(0, 9) < 7)
      b[F_MASS*VW +: VW] = $urandom_range(1, 50 << FB);
    return b;
  endfunction

  function automatic logic [1:0] rnd_kind();
    case ($urandom_range(0, 9))
      0: return rbei_pkg::KIND_INERT;
      1: return rbei_pkg::KIND_UNUSED;
      2, 3, 4: return rbei_pkg::KIND_KINEMATIC;
      default: return rbei_pkg::KIND_DYNAMIC;
    endcase
  endfunction

  function automatic body_t mk(logic [31:0] mass, logic [31:0] gs, logic [31:0] f,
                               logic [31:0] v, logic [31:0] damp, logic [31:0] lim,
                               logic [31:0] p);
    return {p, p, lim, lim, damp, v, v, f, f, gs, mass};
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random tready, one long hold-off to back up the pipe
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (!stall_done && results_seen >= 300) begin
        stall_done = 1'b1;
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser);
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] worlds[5][3];
    logic [1:0] k;
    worlds = '{
      '{32'h0000_0000, 32'hfff6_3334, 32'h0000_0444},  // earth-like, 1/60 s
      '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},  // extremes everywhere
      '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001},  // smallest step
      '{32'h0001_8000, 32'h0003_0000, 32'h0001_0000},  // one second step
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}   // back to no update
    };
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: step still zero after reset
    send_body(rbei_pkg::KIND_DYNAMIC, mk(32'h0001_0000, 32'h0001_0000, 32'h0005_0000,
                                         32'h0002_0000, 32'h0, 32'h0, 32'h0010_0000));
    send_body(rbei_pkg::KIND_KINEMATIC, rnd_body(rbei_pkg::KIND_KINEMATIC));
    send_body(rbei_pkg::KIND_INERT, rnd_body(rbei_pkg::KIND_INERT));
    drain();

    set_world(32'h0000_0000, 32'hfff6_3334, 32'h0000_1000);
    send_body(rbei_pkg::KIND_INERT, rnd_body(rbei_pkg::KIND_INERT));
    send_body(rbei_pkg::KIND_UNUSED, rnd_body(rbei_pkg::KIND_DYNAMIC));  // unused kind
    send_body(rbei_pkg::KIND_DYNAMIC,
              mk(32'h0, 32'h0001_0000, 32'h1, 32'h1, 0, 0, 0));   // zero mass
    send_body(rbei_pkg::KIND_DYNAMIC,
              mk(32'h8000_0000, 32'h1, 32'h1, 32'h1, 0, 0, 0));   // negative mass
    send_body(rbei_pkg::KIND_DYNAMIC, mk(32'h0002_0000, 32'h0001_0000, 32'h0004_0000,
                                         32'h0001_0000, 32'h0000_8000, 32'h0,
                                         32'h0003_0000));
    send_body(rbei_pkg::KIND_DYNAMIC, mk(32'h1, 32'h0001_0000, 32'h7fff_ffff,
                                         32'h0, 32'h0, 32'h0, 32'h0)); // force/mass saturates
    send_body(rbei_pkg::KIND_DYNAMIC, mk(32'h0001_0000, 32'h0, 32'h0, 32'h0010_0000,
                                         32'h8000_0000, 32'h0, 32'h0)); // negative damping
    send_body(rbei_pkg::KIND_DYNAMIC, mk(32'h0001_0000, 32'h0, 32'h0, 32'h0010_0000,
                                         32'h7fff_ffff, 32'h0, 32'h0)); // factor below zero
    send_body(rbei_pkg::KIND_KINEMATIC, mk(0, 0, 0, 32'h0050_0000, 0, 32'h0002_0000, 0));
    send_body(rbei_pkg::KIND_KINEMATIC, mk(0, 0, 0, 32'hffb0_0000, 0, 32'h0002_0000, 0));
    send_body(rbei_pkg::KIND_KINEMATIC,
              mk(0, 0, 0, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff));
    send_body(rbei_pkg::KIND_KINEMATIC,
              mk(0, 0, 0, 32'h8000_0000, 0, 32'h0, 32'h8000_0000));
    send_body(rbei_pkg::KIND_DYNAMIC, mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                         32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
                                         32'h8000_0000));
    drain();

    // random phases, one per world setting
    for (int w = 0; w < 5; w++) begin
      set_world(worlds[w][0], worlds[w][1], worlds[w][2]);
      no_gaps = (w == 3);
      for (int n = 0; n < 200; n++) begin
        k = rnd_kind();
        send_body(k, rnd_body(k));
      end
      drain();
    end

    repeat (LAT + 20) @(posedge clk_i);
    $display("Covered %0d bodies over 7 world settings: moved %0d, inert %0d,",
             results_seen, sb.per_outcome[rbei_pkg::OUT_MOVED],
             sb.per_outcome[rbei_pkg::OUT_INERT]);
    $display("bad mass %0d, zero step %0d; long output hold-off exercised: %0d",
             sb.per_outcome[rbei_pkg::OUT_BAD_MASS],
             sb.per_outcome[rbei_pkg::OUT_ZERO_DT], stall_done);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending.size() != 0) $error("%0d results never arrived", sb.pending.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
